// ----- sv/dde_pkg.sv -----
// shared constants for the direct dft engine
// widths of samples, twiddles, products, accumulators and config codes; no dependencies
package dde_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int SAMPLE_W   = 16;
    localparam int TW_FRAC    = 15;
    localparam int TW_W       = TW_FRAC + 2;
    localparam int PROD_W     = 2 * TW_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int ACC_W      = SUM_W + IDX_W;
    localparam int SHIFT_W    = ACC_W - TW_FRAC;
    localparam int BIN_W      = 24;
    localparam int DIV_STEPS  = SHIFT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POINT_COUNT  = 4'd0,
        REG_INVERSE_MODE = 4'd1,
        REG_BASE_COS     = 4'd2,
        REG_BASE_SIN     = 4'd3
    } cfg_reg_t;

    localparam logic [CNT_W-1:0]           PC_RESET  = CNT_W'(64);
    localparam logic signed [SAMPLE_W-1:0] COS_RESET = SAMPLE_W'(32610);
    localparam logic signed [SAMPLE_W-1:0] SIN_RESET = SAMPLE_W'(3212);

endpackage

// ----- sv/dde_cmul.sv -----
// shared complex multiplier: registered partial products, then registered re/im sums
// uses dde_pkg widths
module dde_cmul (
    input  logic                             clk,
    input  logic signed [dde_pkg::TW_W-1:0]  a_re,
    input  logic signed [dde_pkg::TW_W-1:0]  a_im,
    input  logic signed [dde_pkg::TW_W-1:0]  b_re,
    input  logic signed [dde_pkg::TW_W-1:0]  b_im,
    output logic signed [dde_pkg::SUM_W-1:0] p_re,
    output logic signed [dde_pkg::SUM_W-1:0] p_im
);
    import dde_pkg::*;

    logic signed [PROD_W-1:0] rr_reg;
    logic signed [PROD_W-1:0] ii_reg;
    logic signed [PROD_W-1:0] ri_reg;
    logic signed [PROD_W-1:0] ir_reg;
    logic signed [SUM_W-1:0]  re_reg;
    logic signed [SUM_W-1:0]  im_reg;

    always_ff @(posedge clk)
    begin
        rr_reg <= a_re * b_re;
        ii_reg <= a_im * b_im;
        ri_reg <= a_re * b_im;
        ir_reg <= a_im * b_re;
        re_reg <= SUM_W'(rr_reg) - SUM_W'(ii_reg);
        im_reg <= SUM_W'(ri_reg) + SUM_W'(ir_reg);
    end

    assign p_re = re_reg;
    assign p_im = im_reg;

endmodule

// ----- sv/dde_div.sv -----
// radix-2 restoring divider for both bin parts, truncating toward zero
// one quotient bit per cycle; uses dde_pkg widths
module dde_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [dde_pkg::CNT_W-1:0]          divisor,
    input  logic signed [dde_pkg::SHIFT_W-1:0] num_re,
    input  logic signed [dde_pkg::SHIFT_W-1:0] num_im,
    output logic                               done,
    output logic signed [dde_pkg::SHIFT_W:0]   quo_re,
    output logic signed [dde_pkg::SHIFT_W:0]   quo_im
);
    import dde_pkg::*;

    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0]     den_reg;
    logic [CNT_W-1:0]     rem_re_reg;
    logic [CNT_W-1:0]     rem_im_reg;
    logic [SHIFT_W-1:0]   q_re_reg;
    logic [SHIFT_W-1:0]   q_im_reg;
    logic                 neg_re_reg;
    logic                 neg_im_reg;
    logic [SHIFT_W-1:0]   mag_re;
    logic [SHIFT_W-1:0]   mag_im;
    logic [CNT_W+SHIFT_W-1:0] step_re;
    logic [CNT_W+SHIFT_W-1:0] step_im;

    function automatic logic [CNT_W+SHIFT_W-1:0] div_step(
        input logic [CNT_W-1:0]   rem,
        input logic [SHIFT_W-1:0] q,
        input logic [CNT_W-1:0]   d
    );
        logic [CNT_W:0] trial;
        logic           ge;
        trial = {rem, q[SHIFT_W-1]};
        ge    = (trial >= {1'b0, d});
        if (ge)
        begin
            trial = trial - {1'b0, d};
        end
        return {trial[CNT_W-1:0], q[SHIFT_W-2:0], ge};
    endfunction

    assign mag_re  = num_re[SHIFT_W-1] ? (~num_re + 1'b1) : num_re;
    assign mag_im  = num_im[SHIFT_W-1] ? (~num_im + 1'b1) : num_im;
    assign step_re = div_step(rem_re_reg, q_re_reg, den_reg);
    assign step_im = div_step(rem_im_reg, q_im_reg, den_reg);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg    <= divisor;
            rem_re_reg <= '0;
            rem_im_reg <= '0;
            q_re_reg   <= mag_re;
            q_im_reg   <= mag_im;
            neg_re_reg <= num_re[SHIFT_W-1];
            neg_im_reg <= num_im[SHIFT_W-1];
        end
        else if (run_reg)
        begin
            {rem_re_reg, q_re_reg} <= step_re;
            {rem_im_reg, q_im_reg} <= step_im;
        end
    end

    assign done   = done_reg;
    assign quo_re = neg_re_reg ? -$signed({1'b0, q_re_reg}) : $signed({1'b0, q_re_reg});
    assign quo_im = neg_im_reg ? -$signed({1'b0, q_im_reg}) : $signed({1'b0, q_im_reg});

endmodule

// ----- sv/direct_dft_engine_top.sv -----
// direct dft engine top level: config registers, sample and twiddle memories, sequencer
// uses dde_pkg, dde_cmul, dde_div
//
// usage: samples are written one beat per start pulse while busy is low; the beat that
// completes point_count samples launches the transform and busy rises until the last bin
// goes out; every bin appears for exactly one cycle with bin_valid high and cannot be
// held off, so the receiver must take it on that cycle; bins leave in order 0..N-1 with
// last_bin on bin N-1; the transform first builds the twiddle table W^k by repeated
// complex multiplication on the shared multiplier (the first two entries are written
// directly in TW0 and TW1, each further one goes through TW_MUL, TW_PROD and TW_WR),
// then for each bin streams N multiply-accumulates through the same multiplier at one
// per cycle and waits in DRAIN for the sum; in inverse mode each bin then goes through
// the radix-2 divider; the transform time is set by the single complex multiplier and
// the one-bit-per-cycle divider;
// config writes are always ready and must only be issued while busy is low
module direct_dft_engine_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [dde_pkg::SAMPLE_W-1:0]   sample_re,
    input  logic signed [dde_pkg::SAMPLE_W-1:0]   sample_im,
    output logic                                  bin_valid,
    output logic signed [dde_pkg::BIN_W-1:0]      bin_re,
    output logic signed [dde_pkg::BIN_W-1:0]      bin_im,
    output logic [dde_pkg::IDX_W-1:0]             bin_index,
    output logic                                  last_bin,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dde_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dde_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import dde_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TW0,
        ST_TW1,
        ST_TW_MUL,
        ST_TW_PROD,
        ST_TW_WR,
        ST_ISSUE,
        ST_DRAIN,
        ST_DIV
    } state_t;

    // tags that travel with each multiply-accumulate beat
    typedef struct packed {
        logic v;
        logic first;
        logic last;
    } mac_tag_t;

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [TW_W-1:0]     TW_ONE  = TW_W'(1 << TW_FRAC);
    localparam logic signed [SUM_W:0]      TW_HALF = (SUM_W+1)'(1 << (TW_FRAC - 1));

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]           pc_reg;
    logic                       inv_reg;
    logic signed [SAMPLE_W-1:0] cos_reg;
    logic signed [SAMPLE_W-1:0] sin_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= PC_RESET;
            inv_reg <= 1'b0;
            cos_reg <= COS_RESET;
            sin_reg <= SIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_POINT_COUNT:  pc_reg  <= cfg_data[CNT_W-1:0];
                REG_INVERSE_MODE: inv_reg <= cfg_data[0];
                REG_BASE_COS:     cos_reg <= cfg_data[SAMPLE_W-1:0];
                REG_BASE_SIN:     sin_reg <= cfg_data[SAMPLE_W-1:0];
                default:          ;   // unknown index, dropped
            endcase
        end
    end

    // effective point count: zero acts as one, oversize clips to the table depth
    logic [CNT_W-1:0]           n_act;
    logic [CNT_W-1:0]           n_last;
    logic signed [SAMPLE_W-1:0] sin_eff;
    logic signed [TW_W-1:0]     cos_ext;
    logic signed [TW_W-1:0]     sin_ext;

    always_comb
    begin
        if (pc_reg == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (pc_reg > CNT_W'(MAX_POINTS))
        begin
            n_act = CNT_W'(MAX_POINTS);
        end
        else
        begin
            n_act = pc_reg;
        end
    end

    assign n_last = n_act - 1'b1;

    // forward mode uses the conjugate base twiddle; -(-1.0) saturates
    always_comb
    begin
        if (inv_reg)
        begin
            sin_eff = sin_reg;
        end
        else if (sin_reg == SMP_MIN)
        begin
            sin_eff = SMP_MAX;
        end
        else
        begin
            sin_eff = -sin_reg;
        end
    end

    assign cos_ext = TW_W'(cos_reg);
    assign sin_ext = TW_W'(sin_eff);

    // ------------------------------------------------------------------
    // sequencer registers
    // ------------------------------------------------------------------
    state_t                     state_reg,    state_next;
    logic [CNT_W-1:0]           load_cnt_reg, load_cnt_next;
    logic [IDX_W-1:0]           i_reg,        i_next;
    logic [IDX_W-1:0]           j_reg,        j_next;
    logic [IDX_W-1:0]           k_reg,        k_next;
    logic signed [TW_W-1:0]     prev_re_reg,  prev_re_next;
    logic signed [TW_W-1:0]     prev_im_reg,  prev_im_next;
    logic                       bin_valid_reg, bin_valid_next;
    logic signed [BIN_W-1:0]    bin_re_reg,   bin_re_next;
    logic signed [BIN_W-1:0]    bin_im_reg,   bin_im_next;
    logic [IDX_W-1:0]           bin_index_reg, bin_index_next;
    logic                       last_bin_reg, last_bin_next;

    logic                       accept;
    logic [CNT_W-1:0]           load_inc;
    logic [CNT_W-1:0]           k_sum;
    logic                       do_emit;
    logic                       tw_we;
    logic [IDX_W-1:0]           tw_wa;
    logic [2*TW_W-1:0]          tw_wd;
    mac_tag_t                   iss_tag;
    logic                       div_start;
    logic                       div_done;
    logic signed [SHIFT_W:0]    div_q_re;
    logic signed [SHIFT_W:0]    div_q_im;
    logic signed [TW_W-1:0]     rnd_re;
    logic signed [TW_W-1:0]     rnd_im;
    logic signed [BIN_W-1:0]    emit_re;
    logic signed [BIN_W-1:0]    emit_im;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // memories: samples and twiddles, one write and one registered read each
    // ------------------------------------------------------------------
    logic [2*SAMPLE_W-1:0] smp_mem [MAX_POINTS];
    logic [2*TW_W-1:0]     tw_mem  [MAX_POINTS];
    logic [2*SAMPLE_W-1:0] smp_rd_reg;
    logic [2*TW_W-1:0]     tw_rd_reg;

    // load_cnt stays below the table depth, see the idle state
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_mem[load_cnt_reg[IDX_W-1:0]] <= {sample_re, sample_im};
        end
        smp_rd_reg <= smp_mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (tw_we)
        begin
            tw_mem[tw_wa] <= tw_wd;
        end
        tw_rd_reg <= tw_mem[k_reg];
    end

    // ------------------------------------------------------------------
    // shared complex multiplier with registered partial products and registered sums
    // twiddle build: prev * base, mac: sample * twiddle
    // ------------------------------------------------------------------
    logic signed [TW_W-1:0]  op_a_re;
    logic signed [TW_W-1:0]  op_a_im;
    logic signed [TW_W-1:0]  op_b_re;
    logic signed [TW_W-1:0]  op_b_im;
    logic signed [SUM_W-1:0] cm_re;
    logic signed [SUM_W-1:0] cm_im;

    always_comb
    begin
        if (state_reg == ST_TW_MUL)
        begin
            op_a_re = prev_re_reg;
            op_a_im = prev_im_reg;
            op_b_re = cos_ext;
            op_b_im = sin_ext;
        end
        else
        begin
            op_a_re = TW_W'($signed(smp_rd_reg[2*SAMPLE_W-1:SAMPLE_W]));
            op_a_im = TW_W'($signed(smp_rd_reg[SAMPLE_W-1:0]));
            op_b_re = $signed(tw_rd_reg[2*TW_W-1:TW_W]);
            op_b_im = $signed(tw_rd_reg[TW_W-1:0]);
        end
    end

    dde_cmul u_cmul (
        .clk  (clk),
        .a_re (op_a_re),
        .a_im (op_a_im),
        .b_re (op_b_re),
        .b_im (op_b_im),
        .p_re (cm_re),
        .p_im (cm_im)
    );

    // ------------------------------------------------------------------
    // tag pipeline and accumulators
    // ------------------------------------------------------------------
    mac_tag_t                rd_tag_reg;
    mac_tag_t                mul_tag_reg;
    mac_tag_t                sum_tag_reg;
    logic                    acc_done_reg;
    logic signed [ACC_W-1:0] acc_re_reg;
    logic signed [ACC_W-1:0] acc_im_reg;
    logic signed [SHIFT_W-1:0] sh_re;
    logic signed [SHIFT_W-1:0] sh_im;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_tag_reg   <= '0;
            mul_tag_reg  <= '0;
            sum_tag_reg  <= '0;
            acc_done_reg <= 1'b0;
        end
        else
        begin
            rd_tag_reg   <= iss_tag;
            mul_tag_reg  <= rd_tag_reg;
            sum_tag_reg  <= mul_tag_reg;
            acc_done_reg <= sum_tag_reg.v && sum_tag_reg.last;
        end
    end

    // first beat of a bin restarts the sum
    always_ff @(posedge clk)
    begin
        if (sum_tag_reg.v)
        begin
            if (sum_tag_reg.first)
            begin
                acc_re_reg <= ACC_W'(cm_re);
                acc_im_reg <= ACC_W'(cm_im);
            end
            else
            begin
                acc_re_reg <= acc_re_reg + ACC_W'(cm_re);
                acc_im_reg <= acc_im_reg + ACC_W'(cm_im);
            end
        end
    end

    // floor shift out the twiddle fraction
    assign sh_re = acc_re_reg[ACC_W-1:TW_FRAC];
    assign sh_im = acc_im_reg[ACC_W-1:TW_FRAC];

    // ------------------------------------------------------------------
    // divider for inverse mode
    // ------------------------------------------------------------------
    dde_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (n_act),
        .num_re  (sh_re),
        .num_im  (sh_im),
        .done    (div_done),
        .quo_re  (div_q_re),
        .quo_im  (div_q_im)
    );

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    // round half up, saturate to the twiddle range
    function automatic logic signed [TW_W-1:0] tw_round(input logic signed [SUM_W-1:0] p);
        logic signed [SUM_W:0]         t;
        logic signed [SUM_W-TW_FRAC:0] r;
        logic signed [SUM_W-TW_FRAC:0] hi;
        logic signed [SUM_W-TW_FRAC:0] lo;
        hi = (SUM_W-TW_FRAC+1)'((1 << TW_FRAC) - 1);
        lo = ~hi;
        t  = (SUM_W+1)'(p) + TW_HALF;
        r  = t[SUM_W:TW_FRAC];
        if (r > hi)
        begin
            r = hi;
        end
        else if (r < lo)
        begin
            r = lo;
        end
        return TW_W'(r);
    endfunction

    // saturate to the bin range
    function automatic logic signed [BIN_W-1:0] sat_bin(input logic signed [SHIFT_W:0] v);
        logic signed [SHIFT_W:0] hi;
        logic signed [SHIFT_W:0] lo;
        logic signed [SHIFT_W:0] r;
        hi = (SHIFT_W+1)'((1 << (BIN_W - 1)) - 1);
        lo = ~hi;
        r  = v;
        if (v > hi)
        begin
            r = hi;
        end
        else if (v < lo)
        begin
            r = lo;
        end
        return BIN_W'(r);
    endfunction

    assign rnd_re  = tw_round(cm_re);
    assign rnd_im  = tw_round(cm_im);
    assign emit_re = inv_reg ? sat_bin(div_q_re) : sat_bin((SHIFT_W+1)'(sh_re));
    assign emit_im = inv_reg ? sat_bin(div_q_im) : sat_bin((SHIFT_W+1)'(sh_im));

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        prev_re_next   = prev_re_reg;
        prev_im_next   = prev_im_reg;
        bin_valid_next = 1'b0;
        bin_re_next    = bin_re_reg;
        bin_im_next    = bin_im_reg;
        bin_index_next = bin_index_reg;
        last_bin_next  = last_bin_reg;
        tw_we          = 1'b0;
        tw_wa          = j_reg;
        tw_wd          = {rnd_re, rnd_im};
        iss_tag        = '0;
        div_start      = 1'b0;
        do_emit        = 1'b0;
        load_inc       = load_cnt_reg + 1'b1;
        k_sum          = {1'b0, k_reg} + {1'b0, i_reg};
        if (k_sum >= n_act)
        begin
            k_sum = k_sum - n_act;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // a lowered point count still fires on the next beat
                if (accept)
                begin
                    if (load_inc >= n_act)
                    begin
                        load_cnt_next = '0;
                        state_next    = ST_TW0;
                    end
                    else
                    begin
                        load_cnt_next = load_inc;
                    end
                end
            end

            ST_TW0:
            begin
                tw_we  = 1'b1;
                tw_wa  = '0;
                tw_wd  = {TW_ONE, {TW_W{1'b0}}};
                i_next = '0;
                j_next = '0;
                k_next = '0;
                if (n_act == CNT_W'(1))
                begin
                    state_next = ST_ISSUE;
                end
                else
                begin
                    state_next = ST_TW1;
                end
            end

            ST_TW1:
            begin
                tw_we        = 1'b1;
                tw_wa        = IDX_W'(1);
                tw_wd        = {cos_ext, sin_ext};
                prev_re_next = cos_ext;
                prev_im_next = sin_ext;
                if (n_act == CNT_W'(2))
                begin
                    j_next     = '0;
                    state_next = ST_ISSUE;
                end
                else
                begin
                    j_next     = IDX_W'(2);
                    state_next = ST_TW_MUL;
                end
            end

            ST_TW_MUL:
            begin
                state_next = ST_TW_PROD;
            end

            ST_TW_PROD:
            begin
                state_next = ST_TW_WR;
            end

            ST_TW_WR:
            begin
                tw_we        = 1'b1;
                prev_re_next = rnd_re;
                prev_im_next = rnd_im;
                if ({1'b0, j_reg} == n_last)
                begin
                    j_next     = '0;
                    state_next = ST_ISSUE;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_TW_MUL;
                end
            end

            ST_ISSUE:
            begin
                // k tracks (i*j) mod n by stepping i each beat
                iss_tag.v     = 1'b1;
                iss_tag.first = (j_reg == '0);
                iss_tag.last  = ({1'b0, j_reg} == n_last);
                if (iss_tag.last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    k_next = k_sum[IDX_W-1:0];
                end
            end

            ST_DRAIN:
            begin
                if (acc_done_reg)
                begin
                    if (inv_reg)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        do_emit = 1'b1;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    do_emit = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_emit)
        begin
            bin_valid_next = 1'b1;
            bin_re_next    = emit_re;
            bin_im_next    = emit_im;
            bin_index_next = i_reg;
            last_bin_next  = ({1'b0, i_reg} == n_last);
            j_next         = '0;
            k_next         = '0;
            if (last_bin_next)
            begin
                state_next = ST_IDLE;
            end
            else
            begin
                i_next     = i_reg + 1'b1;
                state_next = ST_ISSUE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            load_cnt_reg  <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            prev_re_reg   <= '0;
            prev_im_reg   <= '0;
            bin_valid_reg <= 1'b0;
            bin_re_reg    <= '0;
            bin_im_reg    <= '0;
            bin_index_reg <= '0;
            last_bin_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            prev_re_reg   <= prev_re_next;
            prev_im_reg   <= prev_im_next;
            bin_valid_reg <= bin_valid_next;
            bin_re_reg    <= bin_re_next;
            bin_im_reg    <= bin_im_next;
            bin_index_reg <= bin_index_next;
            last_bin_reg  <= last_bin_next;
        end
    end

    assign bin_valid = bin_valid_reg;
    assign bin_re    = bin_re_reg;
    assign bin_im    = bin_im_reg;
    assign bin_index = bin_index_reg;
    assign last_bin  = last_bin_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // a finished sum only arrives while the sequencer waits for it
    a_acc_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        acc_done_reg |-> (state_reg == ST_DRAIN))
        else $error("accumulator finished outside drain");

    // divider completion only while waiting on it
    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide wait");

    // read addresses stay inside the active transform
    a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> (({1'b0, k_reg} < n_act) && ({1'b0, j_reg} < n_act)))
        else $error("mac address beyond point count");

    // the final bin releases the engine
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (bin_valid && last_bin) |-> !busy)
        else $error("engine still busy after final bin");

    // bins only follow transform work
    a_bin_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid |-> $past(busy))
        else $error("bin emitted without a running transform");

endmodule
